[sv/fla_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Free-list allocator package
// Field widths, command/status/policy codes, configuration indexes and the free table entry type.
// ----------------------------------------------------------------------------
package fla_pkg;

  localparam int ADDR_W = 16;
  localparam int SIZE_W = 17;

  // Commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Fit policies (any other code behaves as worst fit)
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;

  // Configuration register indexes
  localparam logic CFG_FIT_POLICY = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;

  // One free table entry: block start offset and size with header
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
  } entry_t;

endpackage
`default_nettype wire

[sv/free_list_fit_allocator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Free-list fit allocator
// Heap allocator with first, best or worst fit over a free table in RAM.
// ----------------------------------------------------------------------------
// The free table lives in a single-port-write, registered-read RAM of
// FREE_SLOTS entries, kept with the newest entry at the highest used address,
// so a push is one write and a removal copies the newer entries down by one.
// One item is worked at a time. A free pushes its block and then sweeps the
// table for statistics. An allocate searches the table for a fit, closes the
// gap left by the chosen entry by copying the newer entries down, splits off
// any leftover, and then sweeps the table for statistics. The sweeps read the
// table through the RAM read port, one entry per cycle. No clearing pass is
// needed after reset. A finished result sits in an output register, so the
// next item is taken while it waits to be collected.
module free_list_fit_allocator_top #(
  parameter int FREE_SLOTS   = 64,
  parameter int GROW_BYTES   = 4096,
  parameter int HEADER_BYTES = 16,
  parameter int HEAP_BYTES   = 65536
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // Configuration write port
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_index_i,
  input  wire logic [fla_pkg::SIZE_W-1:0] cfg_wdata_i,
  // Input items
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       command_i,
  input  wire logic [fla_pkg::ADDR_W-1:0] request_bytes_i,
  input  wire logic [fla_pkg::ADDR_W-1:0] user_address_i,
  input  wire logic [fla_pkg::SIZE_W-1:0] block_bytes_i,
  // Result items
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [1:0]                      status_o,
  output logic [fla_pkg::ADDR_W-1:0]      granted_address_o,
  output logic [fla_pkg::SIZE_W-1:0]      granted_bytes_o,
  output logic [fla_pkg::SIZE_W-1:0]      free_bytes_o,
  output logic [6:0]                      chunk_count_o,
  output logic [fla_pkg::SIZE_W-1:0]      largest_free_o,
  output logic [fla_pkg::SIZE_W-1:0]      smallest_free_o
);
  import fla_pkg::*;

  localparam int AW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int CW = $clog2(FREE_SLOTS + 1);
  localparam int HW = $clog2(HEAP_BYTES + 1);
  localparam int GW = ((HW > SIZE_W) ? HW : SIZE_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH, S_SHIFT, S_AEND, S_STATS, S_DONE
  } state_e;

  // Free table RAM
  entry_t          mem_q [FREE_SLOTS];
  entry_t          mem_rdata_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_raddr;
  entry_t          mem_wdata;

  state_e          state_q, state_d;
  logic [CW-1:0]   n_q, n_d;
  logic [HW-1:0]   heap_q, heap_d;
  logic [1:0]      policy_q, policy_d;
  logic [SIZE_W-1:0] limit_q, limit_d;

  // Sweep control
  logic [AW-1:0]   ptr_q, ptr_d;
  logic [CW-1:0]   left_q, left_d;
  logic            pend_q, pend_d;
  logic [AW-1:0]   pidx_q, pidx_d;

  // Fit search
  logic [SIZE_W-1:0] needed_q, needed_d;
  logic            found_q, found_d;
  logic [AW-1:0]   ch_idx_q, ch_idx_d;
  entry_t          ch_q, ch_d;

  // Result under construction
  logic [1:0]        res_status_q, res_status_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  logic [SIZE_W-1:0] res_bytes_q, res_bytes_d;
  logic [SIZE_W-1:0] sum_q, sum_d, big_q, big_d, small_q, small_d;
  logic              first_q, first_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [1:0]        o_status_q, o_status_d;
  logic [ADDR_W-1:0] o_addr_q, o_addr_d;
  logic [SIZE_W-1:0] o_bytes_q, o_bytes_d;
  logic [SIZE_W-1:0] o_sum_q, o_sum_d, o_big_q, o_big_d, o_small_q, o_small_d;
  logic [6:0]        o_chunks_q, o_chunks_d;

  logic [GW-1:0]     grown;
  logic [SIZE_W-1:0] leftover;
  logic [SIZE_W:0]   sum_ext;
  logic [SIZE_W-1:0] rd_size;

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign status_o          = o_status_q;
  assign granted_address_o = o_addr_q;
  assign granted_bytes_o   = o_bytes_q;
  assign free_bytes_o      = o_sum_q;
  assign chunk_count_o     = o_chunks_q;
  assign largest_free_o    = o_big_q;
  assign smallest_free_o   = o_small_q;

  assign grown    = GW'(heap_q) + GW'(GROW_BYTES);
  assign leftover = ch_q.size - needed_q;
  assign rd_size  = mem_rdata_q.size;
  assign sum_ext  = (SIZE_W+1)'(sum_q) + (SIZE_W+1)'(rd_size);

  // RAM: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_raddr];
  end

  // Next-state logic
  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    heap_d       = heap_q;
    policy_d     = policy_q;
    limit_d      = limit_q;
    ptr_d        = ptr_q;
    left_d       = left_q;
    pend_d       = pend_q;
    pidx_d       = pidx_q;
    needed_d     = needed_q;
    found_d      = found_q;
    ch_idx_d     = ch_idx_q;
    ch_d         = ch_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    res_bytes_d  = res_bytes_q;
    sum_d        = sum_q;
    big_d        = big_q;
    small_d      = small_q;
    first_d      = first_q;
    out_valid_d  = out_valid_q;
    o_status_d   = o_status_q;
    o_addr_d     = o_addr_q;
    o_bytes_d    = o_bytes_q;
    o_sum_d      = o_sum_q;
    o_big_d      = o_big_q;
    o_small_d    = o_small_q;
    o_chunks_d   = o_chunks_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_raddr    = ptr_q;

    // Configuration writes
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FIT_POLICY: policy_d = cfg_wdata_i[1:0];
        CFG_HEAP_LIMIT: limit_d  = cfg_wdata_i;
      endcase
    end

    // Result taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_status_d = ST_OK;
          res_addr_d   = '0;
          res_bytes_d  = '0;
          found_d      = 1'b0;
          pend_d       = 1'b0;
          if (command_i == CMD_FREE) begin
            if (user_address_i != '0) begin
              if (n_q >= CW'(FREE_SLOTS)) begin
                res_status_d = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(n_q);
                mem_wdata = '{start: user_address_i - ADDR_W'(HEADER_BYTES),
                              size: block_bytes_i};
                n_d       = n_q + CW'(1);
              end
            end
            state_d = S_STATS;
          end else if (request_bytes_i == '0) begin
            res_status_d = ST_INVALID;
            state_d      = S_STATS;
          end else begin
            needed_d = SIZE_W'(request_bytes_i) + SIZE_W'(HEADER_BYTES);
            ptr_d    = AW'(n_q - CW'(1));
            left_d   = n_q;
            state_d  = S_SRCH;
          end
        end
      end

      // Newest entry first: walk the RAM downward
      S_SRCH: begin
        if (pend_q && (rd_size >= needed_q)) begin
          priority if (!found_q) begin
            found_d  = 1'b1;
            ch_idx_d = pidx_q;
            ch_d     = mem_rdata_q;
          end else if (policy_q == POL_FIRST) begin
            found_d = 1'b1;
          end else if (policy_q == POL_BEST) begin
            if (rd_size < ch_q.size) begin
              ch_idx_d = pidx_q;
              ch_d     = mem_rdata_q;
            end
          end else begin
            if (rd_size > ch_q.size) begin
              ch_idx_d = pidx_q;
              ch_d     = mem_rdata_q;
            end
          end
        end
        if (left_q != '0) begin
          mem_raddr = ptr_q;
          pend_d    = 1'b1;
          pidx_d    = ptr_q;
          ptr_d     = ptr_q - AW'(1);
          left_d    = left_q - CW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            priority if (found_q) begin
              ptr_d   = ch_idx_q + AW'(1);
              left_d  = n_q - CW'(1) - CW'(ch_idx_q);
              state_d = S_SHIFT;
            end else if (((limit_q != '0) && (grown > GW'(limit_q))) ||
                         (grown > GW'(HEAP_BYTES))) begin
              res_status_d = ST_NOFIT;
              state_d      = S_STATS;
            end else if (n_q >= CW'(FREE_SLOTS)) begin
              res_status_d = ST_FULL;
              state_d      = S_STATS;
            end else begin
              // Grow the heap; the new block is the only one that can fit
              mem_we    = 1'b1;
              mem_waddr = AW'(n_q);
              mem_wdata = '{start: ADDR_W'(heap_q), size: SIZE_W'(GROW_BYTES)};
              n_d       = n_q + CW'(1);
              heap_d    = HW'(grown);
              if (SIZE_W'(GROW_BYTES) >= needed_q) begin
                ch_idx_d = AW'(n_q);
                ch_d     = mem_wdata;
                state_d  = S_AEND;
              end else begin
                res_status_d = ST_NOFIT;
                state_d      = S_STATS;
              end
            end
          end
        end
      end

      // Close the gap: copy each newer entry down by one
      S_SHIFT: begin
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = pidx_q - AW'(1);
          mem_wdata = mem_rdata_q;
        end
        if (left_q != '0) begin
          mem_raddr = ptr_q;
          pend_d    = 1'b1;
          pidx_d    = ptr_q;
          ptr_d     = ptr_q + AW'(1);
          left_d    = left_q - CW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = S_AEND;
          end
        end
      end

      // Drop the chosen entry, split off a leftover into the table's top slot
      S_AEND: begin
        res_status_d = ST_OK;
        res_addr_d   = ch_q.start + ADDR_W'(HEADER_BYTES);
        if (leftover > SIZE_W'(HEADER_BYTES)) begin
          mem_we      = 1'b1;
          mem_waddr   = AW'(n_q - CW'(1));
          mem_wdata   = '{start: ch_q.start + needed_q[ADDR_W-1:0], size: leftover};
          res_bytes_d = needed_q;
        end else begin
          n_d         = n_q - CW'(1);
          res_bytes_d = ch_q.size;
        end
        state_d = S_STATS;
      end

      // Totals and extremes over the table
      S_STATS: begin
        if (pend_q) begin
          sum_d = sum_ext[SIZE_W] ? '1 : sum_ext[SIZE_W-1:0];
          if (first_q) begin
            big_d   = rd_size;
            small_d = rd_size;
            first_d = 1'b0;
          end else begin
            if (rd_size > big_q) big_d = rd_size;
            if (rd_size < small_q) small_d = rd_size;
          end
        end
        if (left_q != '0) begin
          mem_raddr = ptr_q;
          pend_d    = 1'b1;
          pidx_d    = ptr_q;
          ptr_d     = ptr_q + AW'(1);
          left_d    = left_q - CW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          o_status_d  = res_status_q;
          o_addr_d    = res_addr_q;
          o_bytes_d   = res_bytes_q;
          o_sum_d     = sum_q;
          o_big_d     = big_q;
          o_small_d   = small_q;
          o_chunks_d  = (32'(n_q) > 32'd127) ? 7'd127 : 7'(n_q);
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // Start of the statistics sweep
    if ((state_d == S_STATS) && (state_q != S_STATS)) begin
      ptr_d   = '0;
      left_d  = n_d;
      pend_d  = 1'b0;
      first_d = 1'b1;
      sum_d   = '0;
      big_d   = '0;
      small_d = '0;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      n_q          <= '0;
      heap_q       <= '0;
      policy_q     <= POL_FIRST;
      limit_q      <= '0;
      ptr_q        <= '0;
      left_q       <= '0;
      pend_q       <= 1'b0;
      pidx_q       <= '0;
      needed_q     <= '0;
      found_q      <= 1'b0;
      ch_idx_q     <= '0;
      ch_q         <= '0;
      res_status_q <= ST_OK;
      res_addr_q   <= '0;
      res_bytes_q  <= '0;
      sum_q        <= '0;
      big_q        <= '0;
      small_q      <= '0;
      first_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      o_status_q   <= ST_OK;
      o_addr_q     <= '0;
      o_bytes_q    <= '0;
      o_sum_q      <= '0;
      o_big_q      <= '0;
      o_small_q    <= '0;
      o_chunks_q   <= '0;
    end else begin
      state_q      <= state_d;
      n_q          <= n_d;
      heap_q       <= heap_d;
      policy_q     <= policy_d;
      limit_q      <= limit_d;
      ptr_q        <= ptr_d;
      left_q       <= left_d;
      pend_q       <= pend_d;
      pidx_q       <= pidx_d;
      needed_q     <= needed_d;
      found_q      <= found_d;
      ch_idx_q     <= ch_idx_d;
      ch_q         <= ch_d;
      res_status_q <= res_status_d;
      res_addr_q   <= res_addr_d;
      res_bytes_q  <= res_bytes_d;
      sum_q        <= sum_d;
      big_q        <= big_d;
      small_q      <= small_d;
      first_q      <= first_d;
      out_valid_q  <= out_valid_d;
      o_status_q   <= o_status_d;
      o_addr_q     <= o_addr_d;
      o_bytes_q    <= o_bytes_d;
      o_sum_q      <= o_sum_d;
      o_big_q      <= o_big_d;
      o_small_q    <= o_small_d;
      o_chunks_q   <= o_chunks_d;
    end
  end

`ifndef SYNTHESIS
  // Table count never exceeds the RAM depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CW'(FREE_SLOTS))
    else $error("free table count beyond depth");

  // Heap growth stays within the heap
  a_heap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    GW'(heap_q) <= GW'(HEAP_BYTES))
    else $error("heap grown beyond heap size");

  // RAM writes never land above the first unused slot
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (CW'(mem_waddr) <= n_q))
    else $error("free table write outside used range");

  // Once the output register can take it, a finished result is presented on the next cycle
  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !(out_valid_q && out_stall_i)) |=>
      (out_valid_q && state_q == S_IDLE))
    else $error("finished result not presented");
`endif

endmodule
`default_nettype wire

[test/tb_free_list_fit_allocator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free-list fit allocator testbench
// Drives alloc and free items through the valid/stall handshake, predicts
// every result with a behavioral copy of the free table, and compares each
// result field by field. Runs several fit policies and heap limits.
// ----------------------------------------------------------------------------
module tb_free_list_fit_allocator_top;
  import fla_pkg::*;

  localparam int SLOTS   = 64;
  localparam int GROW    = 4096;
  localparam int HDR     = 16;
  localparam int HEAP    = 65536;
  localparam int WD_MAX  = 20000;
  localparam int SETTLE  = 300;
  localparam logic [1:0] POL_WORST  = 2'd2;
  localparam logic [1:0] POL_UNUSED = 2'd3;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] req;
    logic [ADDR_W-1:0] uaddr;
    logic [SIZE_W-1:0] bbytes;
  } op_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] bytes;
    logic [SIZE_W-1:0] fbytes;
    logic [6:0]        chunks;
    logic [SIZE_W-1:0] big;
    logic [SIZE_W-1:0] tiny;
  } res_t;

  logic clk, rst_n;
  logic cfg_we, cfg_index;
  logic [SIZE_W-1:0] cfg_wdata;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = 1'b0;
  logic [ADDR_W-1:0] request_bytes = '0, user_address = '0;
  logic [SIZE_W-1:0] block_bytes = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [ADDR_W-1:0] granted_address;
  logic [SIZE_W-1:0] granted_bytes, free_bytes, largest_free, smallest_free;
  logic [6:0] chunk_count;

  free_list_fit_allocator_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(command), .request_bytes_i(request_bytes),
    .user_address_i(user_address), .block_bytes_i(block_bytes),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .granted_address_o(granted_address),
    .granted_bytes_o(granted_bytes), .free_bytes_o(free_bytes),
    .chunk_count_o(chunk_count), .largest_free_o(largest_free),
    .smallest_free_o(smallest_free)
  );

  // Predictor state: free table, head at index 0
  logic [ADDR_W-1:0] tbl_start [SLOTS];
  logic [SIZE_W-1:0] tbl_size  [SLOTS];
  int unsigned n_free, grown;
  logic [1:0] policy;
  logic [SIZE_W-1:0] limit;

  op_t  pending_ops[$];
  res_t expected_results[$];
  int   errors, n_alloc_ok, n_full, n_nofit;
  int   watchdog = 0;
  int   send_idle_pct, recv_idle_pct;
  bit   hold_off;

  // Live-block bookkeeping so frees look like real returns
  logic [ADDR_W-1:0] live_addr[$];
  logic [SIZE_W-1:0] live_size[$];

  function automatic bit push_head(logic [ADDR_W-1:0] s, logic [SIZE_W-1:0] sz);
    if (n_free >= SLOTS) return 0;
    for (int i = n_free; i > 0; i--) begin
      tbl_start[i] = tbl_start[i-1];
      tbl_size[i]  = tbl_size[i-1];
    end
    tbl_start[0] = s;
    tbl_size[0]  = sz;
    n_free++;
    return 1;
  endfunction

  function automatic int find_fit(int unsigned needed);
    int chosen;
    chosen = -1;
    for (int i = 0; i < n_free; i++) begin
      if (tbl_size[i] < needed) continue;
      if (policy == POL_FIRST) return i;
      if (chosen < 0) chosen = i;
      else if (policy == POL_BEST && tbl_size[i] < tbl_size[chosen]) chosen = i;
      else if (policy != POL_BEST && tbl_size[i] > tbl_size[chosen]) chosen = i;
    end
    return chosen;
  endfunction

  function automatic res_t allocator_step(op_t op);
    res_t r;
    int idx;
    int unsigned needed, st, sz, left, sum;
    r = '0;
    if (op.cmd == CMD_ALLOC) begin
      if (op.req == 0) r.status = ST_INVALID;
      else begin
        needed = op.req + HDR;
        idx = find_fit(needed);
        if (idx < 0) begin
          if ((limit != 0 && grown + GROW > limit) || grown + GROW > HEAP)
            r.status = ST_NOFIT;
          else if (n_free >= SLOTS) r.status = ST_FULL;
          else begin
            void'(push_head(grown[ADDR_W-1:0], SIZE_W'(GROW)));
            grown += GROW;
            idx = find_fit(needed);
            if (idx < 0) r.status = ST_NOFIT;
          end
        end
        if (idx >= 0) begin
          st = tbl_start[idx];
          sz = tbl_size[idx];
          for (int i = idx; i + 1 < n_free; i++) begin
            tbl_start[i] = tbl_start[i+1];
            tbl_size[i]  = tbl_size[i+1];
          end
          n_free--;
          left = sz - needed;
          if (left > HDR) begin
            void'(push_head(ADDR_W'(st + needed), SIZE_W'(left)));
            sz = needed;
          end
          r.addr  = ADDR_W'(st + HDR);
          r.bytes = SIZE_W'(sz);
        end
      end
    end else if (op.uaddr != 0) begin
      if (!push_head(ADDR_W'(op.uaddr - HDR), op.bbytes)) r.status = ST_FULL;
    end
    // statistics over the table after the item
    sum = 0;
    for (int i = 0; i < n_free; i++) begin
      sum += tbl_size[i];
      if (sum > 131071) sum = 131071;
      if (i == 0) begin
        r.big = tbl_size[i];
        r.tiny = tbl_size[i];
      end else begin
        if (tbl_size[i] > r.big) r.big = tbl_size[i];
        if (tbl_size[i] < r.tiny) r.tiny = tbl_size[i];
      end
    end
    r.fbytes = SIZE_W'(sum);
    r.chunks = 7'(n_free);
    return r;
  endfunction

  // Clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Driver: present queued items, idle at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        expected_results.push_back(allocator_step(pending_ops[0]));
        void'(pending_ops.pop_front());
      end
      if (pending_ops.size() > 0 && !hold_off &&
          $urandom_range(99) >= send_idle_pct) begin
        op_t nx;
        nx = pending_ops[0];
        in_valid <= 1;
        command <= nx.cmd;
        request_bytes <= nx.req;
        user_address <= nx.uaddr;
        block_bytes <= nx.bbytes;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Monitor: stall at random and check each result
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result, status %0d", status);
          errors++;
        end else begin
          res_t e;
          e = expected_results.pop_front();
          if (status !== e.status) begin
            $error("status exp %0d got %0d", e.status, status); errors++;
          end
          if (granted_address !== e.addr) begin
            $error("granted_address exp %0d got %0d", e.addr, granted_address); errors++;
          end
          if (granted_bytes !== e.bytes) begin
            $error("granted_bytes exp %0d got %0d", e.bytes, granted_bytes); errors++;
          end
          if (free_bytes !== e.fbytes) begin
            $error("free_bytes exp %0d got %0d", e.fbytes, free_bytes); errors++;
          end
          if (chunk_count !== e.chunks) begin
            $error("chunk_count exp %0d got %0d", e.chunks, chunk_count); errors++;
          end
          if (largest_free !== e.big) begin
            $error("largest_free exp %0d got %0d", e.big, largest_free); errors++;
          end
          if (smallest_free !== e.tiny) begin
            $error("smallest_free exp %0d got %0d", e.tiny, smallest_free); errors++;
          end
          if (e.status == ST_OK && e.bytes != 0) n_alloc_ok++;
          if (e.status == ST_FULL) n_full++;
          if (e.status == ST_NOFIT) n_nofit++;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: cycles with no accepted item on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WD_MAX) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic op_t mk_alloc(int unsigned req);
    op_t o;
    o = '0;
    o.cmd = CMD_ALLOC;
    o.req = ADDR_W'(req);
    o.uaddr = ADDR_W'($urandom);
    o.bbytes = SIZE_W'($urandom_range(131071));
    return o;
  endfunction

  function automatic op_t mk_free(int unsigned a, int unsigned b);
    op_t o;
    o.cmd = CMD_FREE;
    o.req = ADDR_W'($urandom);
    o.uaddr = ADDR_W'(a);
    o.bbytes = SIZE_W'(b);
    return o;
  endfunction

  task automatic wait_idle();
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [SIZE_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_FIT_POLICY) policy = val[1:0];
    else limit = val;
  endtask

  // Random phase: alloc-heavy with frees of live blocks, plus noise
  task automatic random_phase(int count);
    int k, r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 50) begin
        k = $urandom_range(9);
        pending_ops.push_back(mk_alloc(k == 0 ? $urandom_range(65535) :
                                       k < 3 ? $urandom_range(1, 2000) :
                                       $urandom_range(1, 200)));
      end else if (r < 90 && live_addr.size() > 0) begin
        k = $urandom_range(live_addr.size() - 1);
        pending_ops.push_back(mk_free(live_addr[k], live_size[k]));
        live_addr.delete(k);
        live_size.delete(k);
      end else if (r < 95) begin
        pending_ops.push_back(mk_free(0, $urandom_range(131071)));
      end else begin
        pending_ops.push_back(mk_free($urandom, $urandom_range(131071)));
      end
    end
  endtask

  // Collect granted blocks from the results as they come in
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && status == ST_OK && granted_bytes != 0) begin
      live_addr.push_back(granted_address);
      live_size.push_back(granted_bytes);
    end
  end

  initial begin
    rst_n = 0;
    cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
    n_free = 0; grown = 0; policy = POL_FIRST; limit = 0;
    errors = 0; n_alloc_ok = 0; n_full = 0; n_nofit = 0;
    send_idle_pct = 9; recv_idle_pct = 78; hold_off = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: field extremes, invalid size, null free, oversize, wrap
    write_reg(CFG_FIT_POLICY, POL_FIRST);
    write_reg(CFG_HEAP_LIMIT, 17'd0);
    pending_ops.push_back(mk_alloc(0));
    pending_ops.push_back(mk_free(0, 17'h1FFFF));
    pending_ops.push_back(mk_alloc(1));
    pending_ops.push_back(mk_alloc(65535));
    pending_ops.push_back(mk_alloc(4080));
    pending_ops.push_back(mk_alloc(4081));
    pending_ops.push_back(mk_free(16'd5, 17'h1FFFF));
    pending_ops.push_back(mk_free(16'hFFFF, 17'd0));
    pending_ops.push_back(mk_alloc(100));
    pending_ops.push_back(mk_alloc(8));
    wait_idle();

    // Best fit with a tight limit
    write_reg(CFG_FIT_POLICY, POL_BEST);
    write_reg(CFG_HEAP_LIMIT, 17'd16384);
    for (int i = 0; i < 10; i++) pending_ops.push_back(mk_alloc($urandom_range(1, 3000)));
    random_phase(300);
    // Hold the sender with items still queued until every result is back
    repeat (200) @(posedge clk);
    hold_off = 1;
    while (in_valid || expected_results.size() != 0) @(posedge clk);
    hold_off = 0;
    wait_idle();

    // Worst fit, heap limit at its top; fill the table with frees
    write_reg(CFG_FIT_POLICY, POL_WORST);
    write_reg(CFG_HEAP_LIMIT, 17'h10000);
    for (int i = 0; i < 70; i++) pending_ops.push_back(mk_free($urandom_range(1, 65535),
                                                              $urandom_range(17, 300)));
    for (int i = 0; i < 5; i++) pending_ops.push_back(mk_alloc(60000));
    random_phase(300);
    wait_idle();

    send_idle_pct = 78; recv_idle_pct = 9;
    write_reg(CFG_FIT_POLICY, POL_UNUSED);
    write_reg(CFG_HEAP_LIMIT, 17'h1FFFF);
    random_phase(500);
    wait_idle();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(CFG_FIT_POLICY, POL_FIRST);
    write_reg(CFG_HEAP_LIMIT, 17'd4095);
    random_phase(200);
    wait_idle();
    write_reg(CFG_HEAP_LIMIT, 17'd0);
    random_phase(600);
    wait_idle();

    $display("Covered all fit policies and limits: %0d grants, %0d no-fit, %0d table-full.",
             n_alloc_ok, n_nofit, n_full);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
